// ===== sv/cda_pkg.sv =====
// Shared constants, codes and calendar helpers for the date advance block.
package cda_pkg;

  // Parameter defaults
  localparam int YEAR_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 10;

  // Field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int REM_W   = 9;  // year modulo 400

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DAYS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MONTHS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_YEARS  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_WRAP    = 2'd2;

  // Calendar constants
  localparam logic [REM_W:0]   LEAP_CYCLE  = 10'd400;
  localparam logic [REM_W-1:0] REM_LAST    = 9'd399;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0] FEB_LEAP    = 5'd29;
  localparam logic [DAY_W-1:0] FEB_COMMON  = 5'd28;

  localparam logic [DAY_W-1:0] MONTH_LEN [13] =
    '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // Leap test from the year modulo 400 (400 is a multiple of 4)
  function automatic logic is_leap(input logic [REM_W-1:0] rem);
    return (rem == '0) ||
           ((rem[1:0] == 2'b00) && (rem != 9'd100) && (rem != 9'd200) && (rem != 9'd300));
  endfunction

  // Month length, zero for a month code outside 1 to 12
  function automatic logic [DAY_W-1:0] days_in(input logic leap,
                                              input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    if (m == '0 || m > MONTH_DEC) begin
      len = '0;
    end else if (m == MONTH_FEB) begin
      len = leap ? FEB_LEAP : FEB_COMMON;
    end else begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

// ===== sv/cda_mod400.sv =====
// Year modulo 400 by reciprocal multiplication: a multiply phase, then a subtract phase.
module cda_mod400 #(
  parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [YEAR_BITS-1:0]        value,
  output logic                        busy,
  output logic [cda_pkg::REM_W-1:0]   rem
);
  import cda_pkg::*;

  // y / 400 = (y >> 4) / 25; the quotient by 25 uses a rounded-up reciprocal,
  // exact for every value of the shifted year at this shift amount
  localparam int XW = YEAR_BITS - 4;
  localparam int SH = XW + 5;
  localparam int RW = XW + 1;
  localparam int PW = XW + RW;
  localparam int QW = YEAR_BITS - 8;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'd24) / 64'd25;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

  localparam logic [1:0] PH_MUL = 2'd2;
  localparam logic [1:0] PH_SUB = 2'd1;

  logic [YEAR_BITS-1:0] val_r;
  logic [QW-1:0]        quo_r;
  logic [REM_W-1:0]     rem_r;
  logic [1:0]           phase_r;
  logic [PW-1:0]        prod;
  logic [YEAR_BITS-1:0] back;
  logic [YEAR_BITS-1:0] diff;

  // Quotient by multiplication, then subtract quotient times 400 (256 + 128 + 16)
  always_comb begin
    prod = PW'(val_r[YEAR_BITS-1:4]) * PW'(RECIP_V);
    back = (YEAR_BITS'(quo_r) << 8) + (YEAR_BITS'(quo_r) << 7) + (YEAR_BITS'(quo_r) << 4);
    diff = val_r - back;
  end

  // Phase counter: multiply, then subtract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (start) begin
      phase_r <= PH_MUL;
    end else if (phase_r != '0) begin
      phase_r <= phase_r - 2'd1;
    end
  end

  // Capture the year, the quotient and the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
    end
    if (phase_r == PH_MUL) begin
      quo_r <= prod[PW-1:SH];
    end
    if (phase_r == PH_SUB) begin
      rem_r <= diff[REM_W-1:0];
    end
  end

  assign busy = (phase_r != '0);
  assign rem  = rem_r;

endmodule

// ===== sv/cda_step_unit.sv =====
// One calendar step: a day, a month or a year added to the held date.
module cda_step_unit #(
  parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEF
) (
  input  logic [cda_pkg::CMD_W-1:0]   cmd,
  input  logic [YEAR_BITS-1:0]        year,
  input  logic [cda_pkg::MONTH_W-1:0] month,
  input  logic [cda_pkg::DAY_W-1:0]   day,
  input  logic [cda_pkg::REM_W-1:0]   rem,
  output logic [YEAR_BITS-1:0]        year_nxt,
  output logic [cda_pkg::MONTH_W-1:0] month_nxt,
  output logic [cda_pkg::DAY_W-1:0]   day_nxt,
  output logic [cda_pkg::REM_W-1:0]   rem_nxt,
  output logic                        wrap
);
  import cda_pkg::*;

  logic [YEAR_BITS-1:0] year_inc;
  logic [REM_W-1:0]     rem_inc;
  logic                 wrap_inc;
  logic                 leap_cur;
  logic                 leap_inc;
  logic [DAY_W-1:0]     lim;
  logic                 carry_year;
  logic [MONTH_W-1:0]   mon_tmp;

  // Next year, its remainder, and the wrap out of the top year
  always_comb begin
    year_inc = year + YEAR_BITS'(1);
    wrap_inc = (year_inc == '0);
    if (wrap_inc || rem == REM_LAST) begin
      rem_inc = '0;
    end else begin
      rem_inc = rem + REM_W'(1);
    end
    leap_cur = is_leap(rem);
    leap_inc = is_leap(rem_inc);
  end

  // Apply the step selected by the command
  always_comb begin
    year_nxt   = year;
    month_nxt  = month;
    day_nxt    = day;
    rem_nxt    = rem;
    carry_year = 1'b0;
    mon_tmp    = month;
    lim        = '0;
    case (cmd)
      CMD_DAYS: begin
        if (day >= days_in(leap_cur, month)) begin
          day_nxt = DAY_W'(1);
          if (month >= MONTH_DEC) begin
            month_nxt  = MONTH_W'(1);
            carry_year = 1'b1;
          end else begin
            month_nxt = month + MONTH_W'(1);
          end
        end else begin
          day_nxt = day + DAY_W'(1);
        end
      end
      CMD_MONTHS: begin
        if (month >= MONTH_DEC) begin
          mon_tmp    = MONTH_W'(1);
          carry_year = 1'b1;
        end else begin
          mon_tmp = month + MONTH_W'(1);
        end
        month_nxt = mon_tmp;
        lim = days_in(carry_year ? leap_inc : leap_cur, mon_tmp);
        if (day > lim) begin
          day_nxt = lim;
        end
      end
      CMD_YEARS: begin
        carry_year = 1'b1;
        if (month == MONTH_FEB && day == FEB_LEAP && !leap_inc) begin
          day_nxt = FEB_COMMON;
        end
      end
      default: begin
        carry_year = 1'b0;
      end
    endcase
    if (carry_year) begin
      year_nxt = year_inc;
      rem_nxt  = rem_inc;
    end
    wrap = carry_year && wrap_inc;
  end

endmodule

// ===== sv/calendar_date_advance.sv =====
// Top level: Gregorian date keeper with load and day/month/year advance commands.
//
//   Channel  Ports                                         Direction
//   in       in_valid/in_ready, cmd, count, load fields    into the block
//   out      out_valid/out_ready, day, month, year, status out of the block
//
// An add command steps the date one step a cycle in ST_STEP through the shared step
// unit until its count is spent, then posts the result from ST_FIN. A load reduces
// the year modulo 400 in ST_MOD, checks the date in ST_CHECK and posts from ST_FIN.
// in_ready returns the cycle after posting; a result still waiting in the output
// register holds the sequencer in its posting state until it is taken.
// Reset (synchronous, active low) sets the date to 1 January of year 1.
module calendar_date_advance #(
  parameter int YEAR_BITS  = cda_pkg::YEAR_BITS_DEF,
  parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cda_pkg::CMD_W-1:0]   in_cmd,
  input  logic [COUNT_BITS-1:0]       in_count,
  input  logic [YEAR_BITS-1:0]        in_load_year,
  input  logic [cda_pkg::MONTH_W-1:0] in_load_month,
  input  logic [cda_pkg::DAY_W-1:0]   in_load_day,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cda_pkg::DAY_W-1:0]   out_day_out,
  output logic [cda_pkg::MONTH_W-1:0] out_month_out,
  output logic [YEAR_BITS-1:0]        out_year_out,
  output logic [cda_pkg::STAT_W-1:0]  out_status
);
  import cda_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]            state_r;
  logic [YEAR_BITS-1:0]  year_r;
  logic [MONTH_W-1:0]    month_r;
  logic [DAY_W-1:0]      day_r;
  logic [REM_W-1:0]      rem_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  wrap_r;
  logic [STAT_W-1:0]     stat_r;
  logic [YEAR_BITS-1:0]  ld_year_r;
  logic [MONTH_W-1:0]    ld_month_r;
  logic [DAY_W-1:0]      ld_day_r;
  logic                  out_valid_r;
  logic [DAY_W-1:0]      out_day_r;
  logic [MONTH_W-1:0]    out_month_r;
  logic [YEAR_BITS-1:0]  out_year_r;
  logic [STAT_W-1:0]     out_stat_r;

  logic                  accept;
  logic                  red_start;
  logic                  red_busy;
  logic [REM_W-1:0]      red_rem;
  logic                  ld_ok;
  logic                  post;
  logic [YEAR_BITS-1:0]  su_year;
  logic [MONTH_W-1:0]    su_month;
  logic [DAY_W-1:0]      su_day;
  logic [REM_W-1:0]      su_rem;
  logic                  su_wrap;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign red_start = accept && (in_cmd == CMD_LOAD);
  assign post      = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  cda_mod400 #(.YEAR_BITS(YEAR_BITS)) u_mod400 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .value (in_load_year),
    .busy  (red_busy),
    .rem   (red_rem)
  );

  cda_step_unit #(.YEAR_BITS(YEAR_BITS)) u_step (
    .cmd       (cmd_r),
    .year      (year_r),
    .month     (month_r),
    .day       (day_r),
    .rem       (rem_r),
    .year_nxt  (su_year),
    .month_nxt (su_month),
    .day_nxt   (su_day),
    .rem_nxt   (su_rem),
    .wrap      (su_wrap)
  );

  // Validate the loaded date against its own year
  always_comb begin
    ld_ok = (ld_day_r != '0) && (ld_day_r <= days_in(is_leap(red_rem), ld_month_r));
  end

  // Sequencer and held date
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      year_r  <= YEAR_BITS'(1);
      month_r <= MONTH_W'(1);
      day_r   <= DAY_W'(1);
      rem_r   <= REM_W'(1);
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= (in_cmd == CMD_LOAD) ? ST_MOD : ST_STEP;
          end
        end
        ST_MOD: begin
          if (!red_busy) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (ld_ok) begin
            year_r  <= ld_year_r;
            month_r <= ld_month_r;
            day_r   <= ld_day_r;
            rem_r   <= red_rem;
          end
          state_r <= ST_FIN;
        end
        ST_STEP: begin
          if (cnt_r == '0) begin
            state_r <= ST_FIN;
          end else begin
            year_r  <= su_year;
            month_r <= su_month;
            day_r   <= su_day;
            rem_r   <= su_rem;
          end
        end
        ST_FIN: begin
          if (post) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the transaction and track the step count and status
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_cmd;
      cnt_r      <= in_count;
      wrap_r     <= 1'b0;
      ld_year_r  <= in_load_year;
      ld_month_r <= in_load_month;
      ld_day_r   <= in_load_day;
    end else if (state_r == ST_STEP && cnt_r != '0) begin
      cnt_r  <= cnt_r - COUNT_BITS'(1);
      wrap_r <= wrap_r || su_wrap;
    end
    if (state_r == ST_CHECK) begin
      stat_r <= ld_ok ? STAT_OK : STAT_INVALID;
    end else if (state_r == ST_STEP) begin
      stat_r <= wrap_r ? STAT_WRAP : STAT_OK;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (post) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      out_day_r   <= day_r;
      out_month_r <= month_r;
      out_year_r  <= year_r;
      out_stat_r  <= stat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_day_out   = out_day_r;
  assign out_month_out = out_month_r;
  assign out_year_out  = out_year_r;
  assign out_status    = out_stat_r;

endmodule
